[sv/atan2pa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package atan2pa_pkg;

  localparam int unsigned QUO_W = 16;
  localparam int unsigned DIV_BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_BITS_PER_STAGE;

  localparam int unsigned Z_W = QUO_W + 1;
  localparam int unsigned ZZ_W = 31;
  localparam int unsigned INNER_W = 48;
  localparam int unsigned SPLIT_LO = 24;
  localparam int unsigned ACC_W = 64;

  localparam logic signed [15:0] COEF_N2 = -16'sd6290;
  localparam logic signed [INNER_W-1:0] N1_Q45 = INNER_W'(64'sd31863 <<< 30);

  localparam logic signed [ACC_W-1:0] PI_Q60 = 64'sh3243F6A8885A308D;
  localparam logic signed [ACC_W-1:0] HALF_PI_Q60 = 64'sh1921FB54442D1846;

  typedef enum logic [2:0] {
    OFF_ZERO,
    OFF_PI,
    OFF_NEG_PI,
    OFF_HALF,
    OFF_NEG_HALF
  } offset_e;

  typedef struct packed {
    logic    neg;
    logic    kill;
    offset_e off;
  } side_t;

endpackage

`default_nettype wire

[sv/atan2pa_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module atan2pa_front #(
  parameter int unsigned WIDTH = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      en_i,
  input  wire                      valid_i,
  input  wire  [WIDTH-1:0]         y_value_i,
  input  wire  [WIDTH-1:0]         x_value_i,
  output logic                     valid_o,
  output logic [WIDTH-1:0]         num_o,
  output logic [WIDTH-1:0]         den_o,
  output atan2pa_pkg::side_t       side_o
);

  logic [WIDTH-1:0]   ax, ay;
  logic               y_neg, x_neg;
  logic               valid_q;
  logic [WIDTH-1:0]   num_d, num_q, den_d, den_q;
  atan2pa_pkg::side_t side_d, side_q;

  assign y_neg = y_value_i[WIDTH-1];
  assign x_neg = x_value_i[WIDTH-1];
  assign ax    = x_neg ? (~x_value_i + 1'b1) : x_value_i;
  assign ay    = y_neg ? (~y_value_i + 1'b1) : y_value_i;

  always_comb begin
    if (ax >= ay) begin
      num_d        = ay;
      den_d        = ax;
      side_d.neg   = y_neg ^ x_neg;
      side_d.kill  = (ax == '0);
      if (x_neg) begin
        side_d.off = y_neg ? atan2pa_pkg::OFF_NEG_PI : atan2pa_pkg::OFF_PI;
      end else begin
        side_d.off = atan2pa_pkg::OFF_ZERO;
      end
    end else begin
      num_d       = ax;
      den_d       = ay;
      side_d.neg  = y_neg ^ x_neg;
      side_d.kill = 1'b0;
      side_d.off  = y_neg ? atan2pa_pkg::OFF_NEG_HALF : atan2pa_pkg::OFF_HALF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

[sv/atan2pa_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module atan2pa_div #(
  parameter int unsigned WIDTH = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire                              valid_i,
  input  wire  [WIDTH-1:0]                 num_i,
  input  wire  [WIDTH-1:0]                 den_i,
  input  atan2pa_pkg::side_t               side_i,
  output logic                             valid_o,
  output logic [atan2pa_pkg::QUO_W-1:0]    quo_o,
  output atan2pa_pkg::side_t               side_o
);

  localparam int unsigned RW = WIDTH + 1;
  localparam int unsigned S  = atan2pa_pkg::DIV_STAGES;
  localparam int unsigned B  = atan2pa_pkg::DIV_BITS_PER_STAGE;
  localparam int unsigned QW = atan2pa_pkg::QUO_W;

  logic [RW-1:0]      rem_q  [S];
  logic [RW-1:0]      den_q  [S];
  logic [QW-1:0]      quo_q  [S];
  atan2pa_pkg::side_t side_q [S];
  logic               vld_q  [S];

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [RW-1:0]      rem_in, den_in, rem_d;
    logic [QW-1:0]      quo_in, quo_d;
    atan2pa_pkg::side_t side_in;
    logic               vld_in;

    if (s == 0) begin : g_first
      assign rem_in  = RW'(num_i);
      assign den_in  = RW'(den_i);
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    always_comb begin
      logic [RW-1:0] r;
      logic [QW-1:0] q;
      r = rem_in;
      q = quo_in;
      for (int b = 0; b < B; b++) begin
        if (r >= den_in) begin
          r = r - den_in;
          q = {q[QW-2:0], 1'b1};
        end else begin
          q = {q[QW-2:0], 1'b0};
        end
        r = {r[RW-2:0], 1'b0};
      end
      rem_d = r;
      quo_d = q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        den_q[s]  <= den_in;
        quo_q[s]  <= quo_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[S-1];
  assign quo_o   = quo_q[S-1];
  assign side_o  = side_q[S-1];

endmodule

`default_nettype wire

[sv/atan2pa_poly.sv]
`timescale 1ns / 1ps
`default_nettype none

module atan2pa_poly #(
  parameter int unsigned ANGLE_FRACTION_BITS = 13
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 en_i,
  input  wire                                 valid_i,
  input  wire  [atan2pa_pkg::QUO_W-1:0]       quo_i,
  input  atan2pa_pkg::side_t                  side_i,
  output logic                                valid_o,
  output logic [ANGLE_FRACTION_BITS+2:0]      angle_o
);

  localparam int unsigned OW    = ANGLE_FRACTION_BITS + 3;
  localparam int unsigned SH    = 60 - ANGLE_FRACTION_BITS;
  localparam int unsigned ZW    = atan2pa_pkg::Z_W;
  localparam int unsigned ZZW   = atan2pa_pkg::ZZ_W;
  localparam int unsigned IW    = atan2pa_pkg::INNER_W;
  localparam int unsigned LO    = atan2pa_pkg::SPLIT_LO;
  localparam int unsigned AW    = atan2pa_pkg::ACC_W;
  localparam int unsigned NST   = 9;
  localparam logic [AW-1:0] RND = AW'(1) << (SH - 1);

  logic [NST-1:0] vld_q;

  logic signed [ZW-1:0]         z_d, z0_q, z1_q, z2_q, z3_q;
  atan2pa_pkg::offset_e         off0_q, off1_q, off2_q, off3_q, off4_q, off5_q;
  logic signed [2*ZW-1:0]       zz_full;
  logic [ZZW-1:0]               zz_q;
  logic signed [IW-1:0]         t_d, t_q;
  logic signed [IW-1:0]         inner_q;
  logic signed [LO+ZW:0]        plo_d, plo_q;
  logic signed [IW-LO+ZW-1:0]   phi_d, phi_q;
  logic signed [AW-1:0]         poly_d, poly_q;
  logic signed [AW-1:0]         total_d, total_q;
  logic [AW-1:0]                rsum_d, rsum_q;
  logic                         neg_q;
  logic [OW-1:0]                mag, angle_d, angle_q;

  assign z_d = side_i.kill ? '0 :
               side_i.neg  ? -$signed({1'b0, quo_i}) : $signed({1'b0, quo_i});

  assign zz_full = z0_q * z0_q;
  assign t_d     = IW'(atan2pa_pkg::COEF_N2) * IW'($signed({1'b0, zz_q}));
  assign plo_d   = $signed({1'b0, inner_q[LO-1:0]}) * z3_q;
  assign phi_d   = $signed(inner_q[IW-1:LO]) * z3_q;
  assign poly_d  = (AW'(phi_q) <<< LO) + AW'(plo_q);

  always_comb begin
    case (off5_q)
      atan2pa_pkg::OFF_PI:       total_d = atan2pa_pkg::PI_Q60 + poly_q;
      atan2pa_pkg::OFF_NEG_PI:   total_d = -atan2pa_pkg::PI_Q60 + poly_q;
      atan2pa_pkg::OFF_HALF:     total_d = atan2pa_pkg::HALF_PI_Q60 - poly_q;
      atan2pa_pkg::OFF_NEG_HALF: total_d = -atan2pa_pkg::HALF_PI_Q60 - poly_q;
      default:                   total_d = poly_q;
    endcase
  end

  assign rsum_d  = total_q[AW-1] ? (~total_q + RND + 1'b1) : (total_q + RND);
  assign mag     = rsum_q[SH +: OW];
  assign angle_d = neg_q ? (~mag + 1'b1) : mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z0_q    <= z_d;
      off0_q  <= side_i.off;
      zz_q    <= zz_full[ZZW-1:0];
      z1_q    <= z0_q;
      off1_q  <= off0_q;
      t_q     <= t_d;
      z2_q    <= z1_q;
      off2_q  <= off1_q;
      inner_q <= atan2pa_pkg::N1_Q45 + t_q;
      z3_q    <= z2_q;
      off3_q  <= off2_q;
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      off4_q  <= off3_q;
      poly_q  <= poly_d;
      off5_q  <= off4_q;
      total_q <= total_d;
      rsum_q  <= rsum_d;
      neg_q   <= total_q[AW-1];
      angle_q <= angle_d;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign angle_o = angle_q;

endmodule

`default_nettype wire

[sv/atan2_polynomial_approx.sv]
`timescale 1ns / 1ps
`default_nettype none

// Four-quadrant arctangent of a signed (y, x) pair from a third-order odd
// polynomial of the smaller-over-larger ratio, angle in radians with
// ANGLE_FRACTION_BITS fraction bits, rounded to nearest. One pair enters per
// clock while the output is not stalled and results leave in order: one input
// stage, an eight-stage radix-2 divider that resolves two quotient bits per
// stage, and nine stages of multiply, offset and rounding. No state links the
// pairs; a stall on the output holds the whole pipeline.
module atan2_polynomial_approx #(
  parameter int unsigned INPUT_WIDTH         = 16,
  parameter int unsigned ANGLE_FRACTION_BITS = 13
) (
  input  wire                                            clk_i,
  input  wire                                            rst_ni,
  input  wire                                            s_axis_tvalid,
  output logic                                           s_axis_tready,
  // y_value, x_value
  input  wire  [((2*INPUT_WIDTH+7)/8)*8-1:0]             s_axis_tdata,
  output logic                                           m_axis_tvalid,
  input  wire                                            m_axis_tready,
  // angle
  output logic [((ANGLE_FRACTION_BITS+3+7)/8)*8-1:0]     m_axis_tdata
);

  localparam int unsigned OW     = ANGLE_FRACTION_BITS + 3;
  localparam int unsigned TDW_O  = ((OW + 7) / 8) * 8;
  localparam int unsigned SH     = 60 - ANGLE_FRACTION_BITS;
  localparam logic signed [OW-1:0] ANG_MAX =
    OW'((atan2pa_pkg::PI_Q60 + (64'sd1 <<< (SH - 1))) >>> SH);

  logic                                advance;
  logic                                f_valid;
  logic [INPUT_WIDTH-1:0]              f_num, f_den;
  atan2pa_pkg::side_t                  f_side;
  logic                                d_valid;
  logic [atan2pa_pkg::QUO_W-1:0]       d_quo;
  atan2pa_pkg::side_t                  d_side;
  logic [OW-1:0]                       angle;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  atan2pa_front #(
    .WIDTH (INPUT_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .valid_i   (s_axis_tvalid),
    .y_value_i (s_axis_tdata[INPUT_WIDTH-1:0]),
    .x_value_i (s_axis_tdata[2*INPUT_WIDTH-1:INPUT_WIDTH]),
    .valid_o   (f_valid),
    .num_o     (f_num),
    .den_o     (f_den),
    .side_o    (f_side)
  );

  atan2pa_div #(
    .WIDTH (INPUT_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (f_valid),
    .num_i   (f_num),
    .den_i   (f_den),
    .side_i  (f_side),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  atan2pa_poly #(
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
  ) u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (d_valid),
    .quo_i   (d_quo),
    .side_i  (d_side),
    .valid_o (m_axis_tvalid),
    .angle_o (angle)
  );

  assign m_axis_tdata = TDW_O'(angle);

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(angle) <= ANG_MAX) && ($signed(angle) >= -ANG_MAX))
    else $error("angle outside [-pi, pi]");

  a_kill_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid && f_side.kill |-> f_side.off == atan2pa_pkg::OFF_ZERO)
    else $error("zero vector carries a nonzero offset");

  a_ratio_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid |-> f_num <= f_den)
    else $error("divider numerator exceeds denominator");

  a_no_deadlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

endmodule

`default_nettype wire
